// File: src/rs3_pkg.sv
// shared types and constants of the rgb 3x3 sharpen block
`timescale 1ns / 1ps

package rs3_pkg;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_STRENGTH = 2'd2
  } cfg_idx_e;

  // register field widths and reset values
  localparam int WidthFieldW = 10;
  localparam int HeightW     = 12;
  localparam int StrW        = 4;
  localparam int WidthReset  = 320;
  localparam int HeightReset = 240;
  localparam int StrReset    = 4;
  localparam int MinDim      = 3;

  // row counter runs up to height + 1 while the frame drains
  localparam int RowW = HeightW + 1;

  // pixel layout: red in the low byte, then green, then blue
  localparam int ChanW   = 8;
  localparam int NumChan = 3;
  localparam int PixW    = ChanW * NumChan;
  localparam int ChanMax = 255;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [PixW-1:0]  pix_t;

  // 3x3 window, row-major, row 0 is the oldest line
  localparam int WinN      = 9;
  localparam int CenterIdx = 4;

  // lane arithmetic widths
  localparam int SumW = ChanW + 3;             // sum of eight neighbors
  localparam int PosW = StrW + 1 + ChanW + 3;  // 8*(k+1)*center
  localparam int NegW = StrW + SumW;           // k*sum

endpackage

// File: src/rs3_line_buf.sv
// two line stores kept side by side in one memory word, registered read
`timescale 1ns / 1ps

module rs3_line_buf #(
  parameter int Depth = 512,
  parameter int AddrW = 9,
  parameter int DataW = 48
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/rs3_lane.sv
// one color channel of the sharpen kernel, two register stages
`timescale 1ns / 1ps

module rs3_lane (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [rs3_pkg::StrW-1:0] k_i,
  input  logic                   border_i,
  input  rs3_pkg::chan_t         win_i [rs3_pkg::WinN],
  output rs3_pkg::chan_t         res_o
);

  import rs3_pkg::*;

  logic [SumW-1:0]   nbr_sum;
  logic [StrW:0]     k_plus1;
  logic [PosW-1:0]   pos_prod;
  logic [PosW-1:0]   pos_d, pos_q;
  logic [NegW-1:0]   neg_d, neg_q;
  chan_t             center_q;
  logic              border_q;
  logic [PosW-1:0]   neg_ext;
  logic [PosW-1:0]   diff;
  logic [PosW-1:0]   quot;
  chan_t             sharp;
  chan_t             res_d, res_q;

  // stage 1: neighbor sum and the two products
  always_comb begin
    nbr_sum = '0;
    for (int i = 0; i < WinN; i++) begin
      if (i != CenterIdx) begin
        nbr_sum = nbr_sum + SumW'(win_i[i]);
      end
    end
  end

  assign k_plus1  = {1'b0, k_i} + (StrW + 1)'(1);
  assign pos_prod = PosW'(k_plus1) * PosW'(win_i[CenterIdx]);
  assign pos_d    = pos_prod << 3;
  assign neg_d    = NegW'(k_i) * NegW'(nbr_sum);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q    <= pos_d;
      neg_q    <= neg_d;
      center_q <= win_i[CenterIdx];
      border_q <= border_i;
    end
  end

  // stage 2: subtract, clamp at zero, divide by 8, cap at full scale; border pixels keep the centre
  assign neg_ext = PosW'(neg_q);
  assign diff    = pos_q - neg_ext;
  assign quot    = diff >> 3;

  always_comb begin
    if (neg_ext > pos_q) begin
      sharp = '0;
    end else if (quot > PosW'(ChanMax)) begin
      sharp = ChanW'(ChanMax);
    end else begin
      sharp = quot[ChanW-1:0];
    end
    res_d = border_q ? center_q : sharp;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: src/rs3_skid.sv
// two-entry output buffer between the pipeline and the result channel
`timescale 1ns / 1ps

module rs3_skid #(
  parameter int Width = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic [Width-1:0] buf_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// File: src/rgb_sharpen_3x3.sv
// top level of the streaming rgb 3x3 sharpen filter
`timescale 1ns / 1ps

// usage
//   pixels enter on the slave stream in raster order, one item per pixel; tuser set
//   marks a flush item. after the last pixel of a frame, image_width + 1 flush items
//   drain the pixels still held in the window; flush items that arrive during the
//   frame are dropped without effect, pixel items during the drain act as flushes.
//   each pixel leaves on the master stream once the pixel one line plus one pixel
//   later has been taken; the first image_width + 1 items of a frame give no output.
//   tlast marks the last pixel of the frame.
//   pipeline: one item per clock sustained while the output buffer has room; a result
//   passes the input register, line store read and window shift, lane products and
//   lane clamp stages, then a two-entry buffer, before it shows on the master side.
//   a stalled receiver fills the two-entry buffer; only when it is full does
//   s_axis_tready_o drop, and the whole pipeline holds in place.
//   config writes go in while the stream is idle; a width or height write restarts
//   the frame, a strength write applies at once. reset loads 320 x 240, strength 4.
//   the line stores have no reset and no clearing pass: no output depends on an
//   entry before it is written in the current frame.

module rgb_sharpen_3x3 #(
  parameter int MAX_WIDTH = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [rs3_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rs3_pkg::CfgDataW-1:0]  cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [rs3_pkg::PixW-1:0]      s_axis_tdata_i,   // red_in, green_in, blue_in
  input  logic [0:0]                    s_axis_tuser_i,   // command
  // output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [rs3_pkg::PixW-1:0]      m_axis_tdata_o,   // red_out, green_out, blue_out
  output logic                          m_axis_tlast_o    // frame_last
);

  import rs3_pkg::*;

  localparam int ColW     = $clog2(MAX_WIDTH);
  localparam int WidW     = $clog2(MAX_WIDTH + 1);
  localparam int WidthRst = (WidthReset > MAX_WIDTH) ? MAX_WIDTH : WidthReset;
  localparam int OutW     = PixW + 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [WidW-1:0]        width_q, width_clamp;
  logic [HeightW-1:0]     height_q, height_clamp;
  logic [StrW-1:0]        strength_q;
  logic [WidthFieldW-1:0] cfg_w;
  logic [HeightW-1:0]     cfg_h;
  logic                   cfg_restart;

  assign cfg_w = cfg_data_i[WidthFieldW-1:0];
  assign cfg_h = cfg_data_i[HeightW-1:0];

  // out-of-range geometry is clamped rather than rejected
  always_comb begin
    if (cfg_w < WidthFieldW'(MinDim)) begin
      width_clamp = WidW'(MinDim);
    end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
      width_clamp = WidW'(MAX_WIDTH);
    end else begin
      width_clamp = WidW'(cfg_w);
    end
    height_clamp = (cfg_h < HeightW'(MinDim)) ? HeightW'(MinDim) : cfg_h;
  end

  assign cfg_restart = cfg_we_i && (cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WidW'(WidthRst);
      height_q   <= HeightW'(HeightReset);
      strength_q <= StrW'(StrReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:    width_q    <= width_clamp;
        CFG_HEIGHT:   height_q   <= height_clamp;
        CFG_STRENGTH: strength_q <= cfg_data_i[StrW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input side: frame position counters and per-item flags
  // ---------------------------------------------------------------------------
  logic             en;          // whole pipeline advances
  logic             acc_in, drain, drop, take;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d, row_end;
  logic [WidW-1:0]  col_inc;
  logic             col_is0, emit_in, border_in, last_in;
  pix_t             px_in;

  assign s_axis_tready_o = en;
  assign acc_in  = s_axis_tvalid_i && s_axis_tready_o;
  assign row_end = RowW'(height_q) + RowW'(1);
  assign drain   = (row_q >= RowW'(height_q));
  assign drop    = !drain && s_axis_tuser_i[0];   // early flush does nothing
  assign take    = acc_in && !drop;
  assign px_in   = drain ? '0 : s_axis_tdata_i;

  // output position is one line plus one pixel behind the input position;
  // at column zero it wraps back to the last column two rows up
  assign col_is0   = (col_q == '0);
  assign emit_in   = (row_q >= RowW'(2)) || (row_q == RowW'(1) && !col_is0);
  assign border_in = col_is0 || (col_q == ColW'(1)) ||
                     (row_q == RowW'(1)) || (row_q == RowW'(height_q));
  assign last_in   = col_is0 && (row_q == row_end);

  assign col_inc = WidW'(col_q) + WidW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (row_q >= row_end) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= width_q) begin
      col_d = '0;
      row_d = row_q + RowW'(1);
    end else begin
      col_d = col_inc[ColW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (take) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage a: item register, line store read in flight
  // ---------------------------------------------------------------------------
  logic            va_q;
  pix_t            px_a_q;
  logic [ColW-1:0] col_a_q;
  logic            emit_a_q, border_a_q, last_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      px_a_q     <= px_in;
      col_a_q    <= col_q;
      emit_a_q   <= emit_in;
      border_a_q <= border_in;
      last_a_q   <= last_in;
    end
  end

  // upper line in the high half, middle line in the low half
  logic [2*PixW-1:0] lb_rdata;
  pix_t              up_px, mid_px;

  rs3_line_buf #(
    .Depth (MAX_WIDTH),
    .AddrW (ColW),
    .DataW (2 * PixW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (take),
    .rd_addr_i (col_q),
    .rd_data_o (lb_rdata),
    .wr_en_i   (en && va_q),
    .wr_addr_i (col_a_q),
    .wr_data_i ({mid_px, px_a_q})
  );

  assign up_px  = lb_rdata[2*PixW-1:PixW];
  assign mid_px = lb_rdata[PixW-1:0];

  // ---------------------------------------------------------------------------
  // stage b: 3x3 window shift
  // ---------------------------------------------------------------------------
  pix_t win_q [WinN];
  logic vb_q;
  logic border_b_q, last_b_q;

  always_ff @(posedge clk_i) begin
    if (cfg_restart) begin
      for (int i = 0; i < WinN; i++) begin
        win_q[i] <= '0;
      end
    end else if (en && va_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= up_px;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= mid_px;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= px_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q && emit_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && va_q) begin
      border_b_q <= border_a_q;
      last_b_q   <= last_a_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stages c and d: one lane per color channel
  // ---------------------------------------------------------------------------
  chan_t lane_res [NumChan];

  for (genvar ch = 0; ch < NumChan; ch++) begin : g_lane
    chan_t lane_win [WinN];

    for (genvar i = 0; i < WinN; i++) begin : g_tap
      assign lane_win[i] = win_q[i][ch*ChanW +: ChanW];
    end

    rs3_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .k_i      (strength_q),
      .border_i (border_b_q),
      .win_i    (lane_win),
      .res_o    (lane_res[ch])
    );
  end

  logic vc_q, vd_q;
  logic last_c_q, last_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_c_q <= last_b_q;
      last_d_q <= last_c_q;
    end
  end

  // ---------------------------------------------------------------------------
  // merge: channels and frame mark into the output buffer
  // ---------------------------------------------------------------------------
  logic [OutW-1:0] merged, out_word;
  pix_t            merged_px;

  always_comb begin
    merged_px = '0;
    for (int ch = 0; ch < NumChan; ch++) begin
      merged_px[ch*ChanW +: ChanW] = lane_res[ch];
    end
  end

  assign merged = {last_d_q, merged_px};

  rs3_skid #(
    .Width (OutW)
  ) u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vd_q),
    .in_ready_o  (en),
    .in_data_i   (merged),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_word)
  );

  assign m_axis_tdata_o = out_word[PixW-1:0];
  assign m_axis_tlast_o = out_word[PixW];

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WidW'(col_q) < width_q)
    else $error("column counter beyond line width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= row_end)
    else $error("row counter beyond end of drain");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && row_q >= row_end) |=> (row_q == '0 && col_q == '0))
    else $error("counters did not wrap after last item of frame");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({va_q, vb_q, vc_q, vd_q}))
    else $error("pipeline moved while output buffer full");

  a_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vb_q && last_b_q) |-> border_b_q)
    else $error("frame end pixel not treated as border");

endmodule

// File: tb/rs3_checker.sv
// stream checker that predicts and compares the output pixels of the rgb 3x3 sharpen filter
`timescale 1ns / 1ps

module rs3_checker #(
  parameter int MAX_WIDTH = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rs3_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rs3_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_i,
  input  logic [rs3_pkg::PixW-1:0]     s_axis_tdata_i,   // red_in, green_in, blue_in
  input  logic [0:0]                   s_axis_tuser_i,   // command
  input  logic                         m_axis_tvalid_i,
  input  logic                         m_axis_tready_i,
  input  logic [rs3_pkg::PixW-1:0]     m_axis_tdata_i,   // red_out, green_out, blue_out
  input  logic                         m_axis_tlast_i,   // frame_last
  output int                           mismatch_cnt_o,
  output int                           pending_o
);

  import rs3_pkg::*;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } px_out_t;

  pix_t    upper_line  [MAX_WIDTH];
  pix_t    middle_line [MAX_WIDTH];
  pix_t    win_px      [WinN];
  int      col_pos, row_pos;
  int      img_w, img_h, strength;
  int      mismatch_cnt = 0;
  px_out_t expected_px_q [$];

  task automatic restart_frame();
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < WinN; i++) win_px[i] = '0;
  endtask

  function automatic chan_t sharpen_lane(int ch);
    int centre, nsum, acc;
    centre = win_px[CenterIdx][ch*ChanW +: ChanW];
    nsum   = 0;
    for (int i = 0; i < WinN; i++)
      if (i != CenterIdx) nsum += win_px[i][ch*ChanW +: ChanW];
    acc = (8 * strength + 8) * centre - strength * nsum;
    if (acc < 0) return '0;
    acc = acc / 8;
    return (acc > ChanMax) ? chan_t'(ChanMax) : chan_t'(acc);
  endfunction

  task automatic apply_cfg();
    int v;
    case (cfg_idx_e'(cfg_idx_i))
      CFG_WIDTH: begin
        v = cfg_data_i[WidthFieldW-1:0];
        if (v < MinDim) v = MinDim;
        if (v > MAX_WIDTH) v = MAX_WIDTH;
        img_w = v;
        restart_frame();
      end
      CFG_HEIGHT: begin
        v = cfg_data_i[HeightW-1:0];
        if (v < MinDim) v = MinDim;
        img_h = v;
        restart_frame();
      end
      CFG_STRENGTH: begin
        strength = cfg_data_i[StrW-1:0];
      end
      default: ;
    endcase
  endtask

  // one accepted item: shift line stores and window, queue the pixel it releases
  task automatic take_item(logic flush, pix_t px_in);
    int      c, orow, ocol;
    pix_t    px, pre, up, mid, centre, res;
    px_out_t exp_px;
    if (row_pos < img_h && flush) return;
    px  = (row_pos >= img_h) ? '0 : px_in;
    c   = col_pos;
    pre = win_px[5];
    up  = upper_line[c];
    mid = middle_line[c];
    upper_line[c]  = mid;
    middle_line[c] = px;
    win_px[0] = win_px[1]; win_px[1] = win_px[2]; win_px[2] = up;
    win_px[3] = win_px[4]; win_px[4] = win_px[5]; win_px[5] = mid;
    win_px[6] = win_px[7]; win_px[7] = win_px[8]; win_px[8] = px;
    if (row_pos >= 2 || (row_pos == 1 && c >= 1)) begin
      if (c == 0) begin
        orow   = row_pos - 2;
        ocol   = img_w - 1;
        centre = pre;
      end else begin
        orow   = row_pos - 1;
        ocol   = c - 1;
        centre = win_px[CenterIdx];
      end
      if (orow == 0 || orow == img_h - 1 || ocol == 0 || ocol == img_w - 1) begin
        res = centre;
      end else begin
        for (int ch = 0; ch < NumChan; ch++) res[ch*ChanW +: ChanW] = sharpen_lane(ch);
      end
      exp_px.red   = res[0 +: ChanW];
      exp_px.green = res[ChanW +: ChanW];
      exp_px.blue  = res[2*ChanW +: ChanW];
      exp_px.last  = (orow == img_h - 1 && ocol == img_w - 1);
      expected_px_q.push_back(exp_px);
    end
    // counters return to zero once the drain is complete
    if (row_pos >= img_h + 1) begin
      row_pos = 0;
      col_pos = 0;
    end else begin
      c++;
      if (c >= img_w) begin
        c = 0;
        row_pos++;
      end
      col_pos = c;
    end
  endtask

  task automatic check_output();
    px_out_t exp_px;
    if (expected_px_q.size() == 0) begin
      mismatch_cnt++;
      $error("output pixel with none expected: tdata %h tlast %b",
             m_axis_tdata_i, m_axis_tlast_i);
    end else begin
      exp_px = expected_px_q.pop_front();
      if (m_axis_tdata_i[0 +: ChanW] !== exp_px.red) begin
        mismatch_cnt++;
        $error("red_out: expected %0d, got %0d", exp_px.red, m_axis_tdata_i[0 +: ChanW]);
      end
      if (m_axis_tdata_i[ChanW +: ChanW] !== exp_px.green) begin
        mismatch_cnt++;
        $error("green_out: expected %0d, got %0d", exp_px.green,
               m_axis_tdata_i[ChanW +: ChanW]);
      end
      if (m_axis_tdata_i[2*ChanW +: ChanW] !== exp_px.blue) begin
        mismatch_cnt++;
        $error("blue_out: expected %0d, got %0d", exp_px.blue,
               m_axis_tdata_i[2*ChanW +: ChanW]);
      end
      if (m_axis_tlast_i !== exp_px.last) begin
        mismatch_cnt++;
        $error("frame_last: expected %0d, got %0d", exp_px.last, m_axis_tlast_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w    = WidthReset;
      img_h    = HeightReset;
      strength = StrReset;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      restart_frame();
      expected_px_q.delete();
      pending_o      <= 0;
      mismatch_cnt_o <= mismatch_cnt;
    end else begin
      if (cfg_we_i) apply_cfg();
      if (s_axis_tvalid_i && s_axis_tready_i) take_item(s_axis_tuser_i[0], s_axis_tdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) check_output();
      pending_o      <= expected_px_q.size();
      mismatch_cnt_o <= mismatch_cnt;
    end
  end

endmodule

// File: tb/tb_rgb_sharpen_3x3.sv
// testbench top of the rgb 3x3 sharpen filter: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module tb_rgb_sharpen_3x3;
  import rs3_pkg::*;

  localparam int MaxWidth   = 512;
  localparam int QuietCyc   = 12;       // pipeline depth plus output buffer, with margin
  localparam int LongHold   = 300;      // receiver hold-off, long enough to fill the block
  localparam int CycleLimit = 500_000;  // far above the slowest correct run
  localparam int TotalItems = 1350;     // items over the whole run

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [PixW-1:0]     s_axis_tdata_i = '0;   // red_in, green_in, blue_in
  logic [0:0]          s_axis_tuser_i = '0;   // command
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [PixW-1:0]     m_axis_tdata_o;        // red_out, green_out, blue_out
  logic                m_axis_tlast_o;        // frame_last

  int          mismatch_cnt;
  int          pending_px;
  int          eff_w, eff_h;             // geometry as the block holds it after clamping
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned cycle_cnt = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rgb_sharpen_3x3 #(.MAX_WIDTH(MaxWidth)) uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o
  );

  rs3_checker #(.MAX_WIDTH(MaxWidth)) chk (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i,
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_o       (pending_px)
  );

  // hard stop if the run hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // channel values lean on the extremes so the clamps on both sides get hit
  function automatic chan_t rand_chan();
    case ($urandom_range(3))
      0:       return '0;
      1:       return chan_t'(ChanMax);
      default: return chan_t'($urandom_range(ChanMax));
    endcase
  endfunction

  function automatic pix_t rand_pix();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  // offer one item, with random gaps in front of it, and wait for the handshake
  task automatic send_item(input logic flush, input pix_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    s_axis_tuser_i  <= flush;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  // stop offering, wait until every predicted pixel is out, then let the pipe go quiet
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_px != 0);
    repeat (QuietCyc) @(posedge clk_i);
  endtask

  // write all three registers back to back; only while the stream is idle
  task automatic program_regs(input int w_raw, input int h_raw, input int k);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WIDTH;
    cfg_data_i <= CfgDataW'(w_raw);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HEIGHT;
    cfg_data_i <= CfgDataW'(h_raw);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_STRENGTH;
    cfg_data_i <= CfgDataW'(k);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    eff_w = (w_raw % 1024 < MinDim) ? MinDim : (w_raw % 1024 > MaxWidth) ? MaxWidth : w_raw;
    eff_h = (h_raw % 4096 < MinDim) ? MinDim : h_raw;
  endtask

  // strength alone does not restart the frame
  task automatic write_strength(input int k);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_STRENGTH;
    cfg_data_i <= CfgDataW'(k);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // pixels in raster order; noise_pct slips in flush items that must be dropped
  task automatic send_pixels(input int n, input int noise_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(1'b1, rand_pix());
      send_item(1'b0, rand_pix());
    end
  endtask

  // width + 1 drain items, now and then a pixel item that must act as a flush
  task automatic drain_frame();
    for (int i = 0; i <= eff_w; i++) send_item($urandom_range(4) != 0, rand_pix());
  endtask

  task automatic send_frame(input int noise_pct);
    send_pixels(eff_w * eff_h, noise_pct);
    drain_frame();
  endtask

  function automatic int rand_strength();
    case ($urandom_range(3))
      0:       return 0;
      1:       return (1 << StrW) - 1;
      default: return $urandom_range((1 << StrW) - 1);
    endcase
  endfunction

  initial begin
    int target_items;
    bit must_program;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: 4 x 3 frame at full strength, tdata packs red in the low byte
    program_regs(4, 3, (1 << StrW) - 1);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b0, 24'h000000);
    send_item(1'b1, 24'hFFFFFF);       // flush inside the frame, dropped
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'hFFFFFF);       // bright centre, mostly dark neighbours, clamps high
    send_item(1'b0, 24'h000000);       // dark centre, clamps to zero
    send_item(1'b0, 24'h00FF00);
    send_item(1'b0, 24'h123456);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'hA5C35A);
    send_item(1'b1, 24'h000000);
    send_item(1'b1, 24'h000000);
    send_item(1'b0, 24'hFFFFFF);       // pixel during the drain, counts as a flush
    send_item(1'b1, 24'h000000);
    send_item(1'b1, 24'h000000);

    // widest line: width above range clamps to the maximum; partial frame, then restart
    settle();
    program_regs(1023, 3, 0);
    send_pixels(520, 0);

    // narrowest line with the tallest frame, partial again
    settle();
    program_regs(0, 4095, (1 << StrW) - 1);
    send_pixels(60, 5);

    // height below range clamps to the minimum, full frame
    settle();
    program_regs(3, 0, 8);
    send_frame(0);

    // random phases, one per idling mode
    must_program = 1'b1;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase

      if (mode == 0) begin
        // receiver holds off while the sender streams: buffer fills, input stalls
        settle();
        program_regs(16, 10, rand_strength());
        hold_req = 1'b1;
        send_frame(0);
        must_program = 1'b0;
      end else if (mode == 1) begin
        // sender waits mid-frame for every result, then strength changes in place
        settle();
        program_regs(12, 8, 3);
        send_pixels(50, 0);
        settle();
        write_strength(12);
        send_pixels(12 * 8 - 50, 0);
        drain_frame();
        must_program = 1'b0;
      end

      // remaining item budget spread over the phases still to come
      target_items = items_sent + (TotalItems - items_sent) / (4 - mode);
      while (items_sent < target_items) begin
        if (must_program || $urandom_range(9) < 6) begin
          settle();
          program_regs($urandom_range(12), $urandom_range(8), rand_strength());
          must_program = 1'b0;
        end
        if ($urandom_range(6) == 0) begin
          // cut the frame short; the next geometry write restarts it
          send_pixels($urandom_range(eff_w * eff_h - 1, 1), 3);
          must_program = 1'b1;
        end else begin
          send_frame(3);
        end
      end
    end

    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_px != 0);
    repeat (2 * QuietCyc) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_px == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
